[rtl/compacting_key_value_table_core_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the compacting key/value table core
// Shared helpers for the port-level checker; clk and rst_n come from scope.
// ---------------------------------------------------------------------------
`ifndef COMPACTING_KEY_VALUE_TABLE_CORE_DEFINES_SVH
`define COMPACTING_KEY_VALUE_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CKVT_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CKVT_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ckvt_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ckvt_pkg
// Request and status codes shared by the front queue and the table back end.
// ---------------------------------------------------------------------------
package ckvt_pkg;

  // Action codes as they arrive on the input channel
  localparam logic [1:0] ACT_LOOKUP   = 2'd0;
  localparam logic [1:0] ACT_INSERT   = 2'd1;
  localparam logic [1:0] ACT_DELETE   = 2'd2;
  localparam logic [1:0] ACT_RESERVED = 2'd3;

  typedef enum logic [1:0] {
    OP_LOOKUP,
    OP_INSERT,
    OP_DELETE,
    OP_PROBE
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_ABSENT  = 2'd1,
    ST_PRESENT = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // Head of the request queue as seen by the back end
  typedef struct packed {
    logic valid;
    op_t  op;
  } qhead_t;

  // Unknown action code only probes the table without touching it
  function automatic op_t classify(input logic [1:0] action);
    op_t op;
    unique case (action)
      ACT_LOOKUP: op = OP_LOOKUP;
      ACT_INSERT: op = OP_INSERT;
      ACT_DELETE: op = OP_DELETE;
      default:    op = OP_PROBE;
    endcase
    return op;
  endfunction

endpackage

[rtl/ckvt_front.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ckvt_front
// Accepts requests, decodes the action and holds them in a two-entry queue.
// ---------------------------------------------------------------------------
module ckvt_front #(
  parameter int KEY_BITS   = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_action,
  input  logic [KEY_BITS-1:0]   in_key,
  input  logic [VALUE_BITS-1:0] in_value,
  output ckvt_pkg::qhead_t      head,
  output logic [KEY_BITS-1:0]   head_key,
  output logic [VALUE_BITS-1:0] head_value,
  input  logic                  head_pop
);
  import ckvt_pkg::*;

  localparam int DEPTH = 2;

  op_t                  op_r  [DEPTH];
  logic [KEY_BITS-1:0]   key_r [DEPTH];
  logic [VALUE_BITS-1:0] val_r [DEPTH];
  logic                 wr_ptr_r, wr_ptr_nxt;
  logic                 rd_ptr_r, rd_ptr_nxt;
  logic [1:0]           cnt_r, cnt_nxt;
  logic                 push;
  logic                 pop;

  assign in_ready = (cnt_r != 2'(DEPTH));
  assign push     = in_valid && in_ready;
  assign pop      = head_pop && (cnt_r != 2'd0);

  assign head.valid = (cnt_r != 2'd0);
  assign head.op    = op_r[rd_ptr_r];
  assign head_key   = key_r[rd_ptr_r];
  assign head_value = val_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      op_r[wr_ptr_r]  <= classify(in_action);
      key_r[wr_ptr_r] <= in_key;
      val_r[wr_ptr_r] <= in_value;
    end
  end

endmodule

[rtl/ckvt_back.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ckvt_back
// Table of packed entry cells with parallel key compare, append on insert,
// shift-down on delete, and the registered result stage.
// ---------------------------------------------------------------------------
module ckvt_back #(
  parameter int CAPACITY   = 16,
  parameter int KEY_BITS   = 16,
  parameter int VALUE_BITS = 32,
  parameter int CNT_W      = $clog2(CAPACITY + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [VALUE_BITS-1:0] cfg_data,
  input  ckvt_pkg::qhead_t      head,
  input  logic [KEY_BITS-1:0]   head_key,
  input  logic [VALUE_BITS-1:0] head_value,
  output logic                  head_pop,
  output logic                  res_valid,
  input  logic                  res_ready,
  output logic                  res_hit,
  output ckvt_pkg::status_t     res_status,
  output logic [VALUE_BITS-1:0] res_read_value,
  output logic [CNT_W-1:0]      res_total,
  output logic                  res_empty,
  output logic                  res_full
);
  import ckvt_pkg::*;

  logic [KEY_BITS-1:0]   key_r [CAPACITY];
  logic [VALUE_BITS-1:0] val_r [CAPACITY];
  logic [KEY_BITS-1:0]   up_key [CAPACITY];
  logic [VALUE_BITS-1:0] up_val [CAPACITY];
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0] undef_r;

  logic [CAPACITY-1:0]   match;
  logic [CAPACITY-1:0]   shift_en;
  logic [CAPACITY-1:0]   ins_sel;
  logic                  hit;
  logic                  is_full;
  logic [VALUE_BITS-1:0] sel_val;
  logic                  do_ins;
  logic                  do_del;
  status_t               status;
  logic [VALUE_BITS-1:0] rd_val;

  logic                  out_valid_r;
  logic                  hit_r;
  status_t               status_r;
  logic [VALUE_BITS-1:0] rd_r;
  logic [CNT_W-1:0]      total_r;

  assign head_pop = head.valid && (!out_valid_r || res_ready);
  assign is_full  = (cnt_r == CNT_W'(CAPACITY));

  always_comb begin
    sel_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match[i]   = (CNT_W'(i) < cnt_r) && (key_r[i] == head_key);
      ins_sel[i] = (CNT_W'(i) == cnt_r);
      // keys are unique, so at most one stored value survives the mask
      sel_val    = sel_val | (match[i] ? val_r[i] : '0);
    end
    shift_en[0] = match[0];
    for (int i = 1; i < CAPACITY; i++) begin
      shift_en[i] = shift_en[i-1] | match[i];
    end
    hit = |match;
  end

  always_comb begin
    do_ins  = 1'b0;
    do_del  = 1'b0;
    cnt_nxt = cnt_r;
    rd_val  = undef_r;
    status  = hit ? ST_DONE : ST_ABSENT;
    unique case (head.op)
      OP_INSERT: begin
        if (hit) begin
          status = ST_PRESENT;
        end else if (is_full) begin
          status = ST_FULL;
        end else begin
          do_ins  = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
          status  = ST_DONE;
        end
      end
      OP_DELETE: begin
        if (hit) begin
          do_del  = 1'b1;
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      OP_LOOKUP: begin
        if (hit) begin
          rd_val = sel_val;
        end
      end
      default: begin
      end
    endcase
  end

  // the top cell has nothing above it and keeps its own entry
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      up_key[i] = key_r[i];
      up_val[i] = val_r[i];
    end
    for (int i = 0; i < CAPACITY - 1; i++) begin
      up_key[i] = key_r[i+1];
      up_val[i] = val_r[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (head_pop) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (do_ins && ins_sel[i]) begin
          key_r[i] <= head_key;
          val_r[i] <= head_value;
        end else if (do_del && shift_en[i]) begin
          // pull the next entry down over the removed one
          key_r[i] <= up_key[i];
          val_r[i] <= up_val[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      undef_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        undef_r <= cfg_data;
      end
      if (head_pop) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (head_pop) begin
      hit_r    <= hit;
      status_r <= status;
      rd_r     <= rd_val;
      total_r  <= cnt_nxt;
    end
  end

  assign res_valid      = out_valid_r;
  assign res_hit        = hit_r;
  assign res_status     = status_r;
  assign res_read_value = rd_r;
  assign res_total      = total_r;
  assign res_empty      = (total_r == '0);
  assign res_full       = (total_r == CNT_W'(CAPACITY));

endmodule

[rtl/compacting_key_value_table_core.sv]
`timescale 1ns / 1ps
// Path: an accepted request is queued, and its result is registered when it is popped.
// Throughput: one request per cycle while results are taken; the queue head drains whenever
//   the result register is empty or being taken, and the cells update as a request is popped.
// Reset: rst_n (synchronous, active low) empties the queue and the table, drops any
//   pending result and sets the undefined value to zero. No clearing pass is needed.
// ---------------------------------------------------------------------------
// compacting_key_value_table_core
// Small associative key/value table kept packed in insertion order.
// ---------------------------------------------------------------------------
module compacting_key_value_table_core #(
  parameter int  CAPACITY   = 16,
  parameter int  KEY_BITS   = 16,
  parameter int  VALUE_BITS = 32,
  localparam int CNT_W      = $clog2(CAPACITY + 1),
  localparam int IN_W       = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8,
  localparam int OUT_W      = ((VALUE_BITS + CNT_W + 2 + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration: undefined_value
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [VALUE_BITS-1:0] cfg_data,
  // requests
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,   // key, value, zero pad
  input  logic [1:0]            in_tuser,   // action
  // results
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_W-1:0]      out_tdata,  // read_value, entry_total, is_empty, is_full, pad
  output logic [2:0]            out_tuser   // hit, status
);
  import ckvt_pkg::*;

  qhead_t                head;
  logic [KEY_BITS-1:0]   head_key;
  logic [VALUE_BITS-1:0] head_value;
  logic                  head_pop;
  logic                  res_hit;
  status_t               res_status;
  logic [VALUE_BITS-1:0] res_read_value;
  logic [CNT_W-1:0]      res_total;
  logic                  res_empty;
  logic                  res_full;

  assign cfg_ready = 1'b1;

  ckvt_front #(
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_action  (in_tuser),
    .in_key     (in_tdata[KEY_BITS-1:0]),
    .in_value   (in_tdata[KEY_BITS +: VALUE_BITS]),
    .head       (head),
    .head_key   (head_key),
    .head_value (head_value),
    .head_pop   (head_pop)
  );

  ckvt_back #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS),
    .CNT_W      (CNT_W)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .head           (head),
    .head_key       (head_key),
    .head_value     (head_value),
    .head_pop       (head_pop),
    .res_valid      (out_tvalid),
    .res_ready      (out_tready),
    .res_hit        (res_hit),
    .res_status     (res_status),
    .res_read_value (res_read_value),
    .res_total      (res_total),
    .res_empty      (res_empty),
    .res_full       (res_full)
  );

  assign out_tdata = OUT_W'({res_full, res_empty, res_total, res_read_value});
  assign out_tuser = {res_status, res_hit};

endmodule

[rtl/ckvt_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ckvt_checker
// Port-level checks on the result channel of the table core.
// ---------------------------------------------------------------------------
`include "compacting_key_value_table_core_defines.svh"

module ckvt_checker #(
  parameter int CAPACITY   = 16,
  parameter int VALUE_BITS = 32,
  parameter int CNT_W      = 5,
  parameter int OUT_W      = 40
) (
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata,
  input logic [2:0]       out_tuser
);
  import ckvt_pkg::*;

  logic             hit;
  status_t          status;
  logic [CNT_W-1:0] total;
  logic             empty;
  logic             full;

  assign hit    = out_tuser[0];
  assign status = status_t'(out_tuser[2:1]);
  assign total  = out_tdata[VALUE_BITS +: CNT_W];
  assign empty  = out_tdata[VALUE_BITS + CNT_W];
  assign full   = out_tdata[VALUE_BITS + CNT_W + 1];

  `CKVT_ASSERT_NEXT(a_stall_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")
  `CKVT_ASSERT_NOW(a_flags_match, out_tvalid,
    (empty == (total == '0)) && (full == (total == CNT_W'(CAPACITY))),
    "empty or full flag disagrees with entry total")
  `CKVT_ASSERT_NOW(a_full_status, out_tvalid && status == ST_FULL,
    full && !hit, "table-full status without a full table or with a hit")
  `CKVT_ASSERT_NOW(a_present_status, out_tvalid && status == ST_PRESENT,
    hit && !empty, "key-present status without a hit")

endmodule

bind compacting_key_value_table_core ckvt_checker #(
  .CAPACITY   (CAPACITY),
  .VALUE_BITS (VALUE_BITS),
  .CNT_W      (CNT_W),
  .OUT_W      (OUT_W)
) u_ckvt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

[bench/compacting_key_value_table_core_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// compacting_key_value_table_core_tb
// Self-checking bench for the compacting key/value table. A scoreboard keeps
// its own copy of the table, predicts one result per accepted request and
// checks every result transfer field by field. A directed sequence covers the
// corner cases, then random phases vary idling, stalls, the insert/delete mix
// and the undefined value register.
// ---------------------------------------------------------------------------
module compacting_key_value_table_core_tb;
  import ckvt_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int IN_W        = 48;
  localparam int OUT_W       = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_ITEMS = 170;
  localparam int POOL_SIZE   = 24;

  // -------------------------------------------------------------------------
  // Scoreboard: shadow table plus queue of predicted results
  // -------------------------------------------------------------------------
  class kv_table_scoreboard;
    typedef struct {
      bit        hit;
      bit [31:0] read_value;
      status_t   status;
      bit [4:0]  total;
      bit        empty;
      bit        full;
    } kv_result_t;

    bit [15:0]   keys[TABLE_DEPTH];
    bit [31:0]   vals[TABLE_DEPTH];
    int          count;
    bit [31:0]   undef_value;
    kv_result_t  result_q[$];
    int          errors;

    function new();
      count       = 0;
      undef_value = '0;
      errors      = 0;
    endfunction

    function void set_undefined(bit [31:0] v);
      undef_value = v;
    endfunction

    function int pending();
      return result_q.size();
    endfunction

    function void note_request(logic [1:0] action, bit [15:0] key, bit [31:0] value);
      kv_result_t r;
      int         slot;
      bit         found;
      slot  = 0;
      found = 1'b0;
      for (int i = 0; i < count; i++) begin
        if (!found && keys[i] == key) begin
          found = 1'b1;
          slot  = i;
        end
      end
      r.hit        = found;
      r.read_value = undef_value;
      case (action)
        ACT_INSERT: begin
          if (found) begin
            r.status = ST_PRESENT;
          end else if (count >= TABLE_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            keys[count] = key;
            vals[count] = value;
            count++;
            r.status = ST_DONE;
          end
        end
        ACT_DELETE: begin
          if (found) begin
            // close the gap left by the removed entry
            for (int i = slot; i + 1 < count; i++) begin
              keys[i] = keys[i + 1];
              vals[i] = vals[i + 1];
            end
            count--;
            r.status = ST_DONE;
          end else begin
            r.status = ST_ABSENT;
          end
        end
        default: begin
          r.status = found ? ST_DONE : ST_ABSENT;
          if (action == ACT_LOOKUP && found) r.read_value = vals[slot];
        end
      endcase
      r.total = count[4:0];
      r.empty = (count == 0);
      r.full  = (count == TABLE_DEPTH);
      result_q.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [OUT_W-1:0] tdata, logic [2:0] tuser);
      kv_result_t r;
      if (result_q.size() == 0) begin
        report($sformatf("unexpected result tdata=%h tuser=%b", tdata, tuser));
      end else begin
        r = result_q.pop_front();
        if (tuser[0] !== r.hit)
          report($sformatf("hit got %b exp %b", tuser[0], r.hit));
        if (tuser[2:1] !== r.status)
          report($sformatf("status got %0d exp %0d", tuser[2:1], r.status));
        if (tdata[31:0] !== r.read_value)
          report($sformatf("read_value got %h exp %h", tdata[31:0], r.read_value));
        if (tdata[36:32] !== r.total)
          report($sformatf("entry_total got %0d exp %0d", tdata[36:32], r.total));
        if (tdata[37] !== r.empty)
          report($sformatf("is_empty got %b exp %b", tdata[37], r.empty));
        if (tdata[38] !== r.full)
          report($sformatf("is_full got %b exp %b", tdata[38], r.full));
      end
    endtask
  endclass

  // -------------------------------------------------------------------------
  // DUT and signals
  // -------------------------------------------------------------------------
  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             cfg_valid  = 1'b0;
  logic             cfg_ready;
  logic [31:0]      cfg_data   = '0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata   = '0;  // key, value, zero pad
  logic [1:0]       in_tuser   = ACT_LOOKUP;  // action
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;  // read_value, entry_total, is_empty, is_full, pad
  logic [2:0]       out_tuser;  // hit, status

  compacting_key_value_table_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  kv_table_scoreboard table_sb;
  int                 sender_idle_pct = 0;
  int                 recv_stall_pct  = 0;
  bit                 hold_req        = 1'b0;
  int                 hold_left       = 0;
  int                 quiet_cycles    = 0;
  bit [15:0]          key_pool[POOL_SIZE];

  initial begin
    forever #4 clk = ~clk;
  end

  // Result side: random stalls, plus a long hold-off when requested
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) table_sb.check_result(out_tdata, out_tuser);
  end

  // Watchdog: count cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[%0t] timeout: no transfer for %0d cycles", $realtime, QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Drivers
  // -------------------------------------------------------------------------
  task send_request(logic [1:0] action, bit [15:0] key, bit [31:0] value);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {value, key};
    in_tuser  <= action;
    do @(posedge clk); while (!in_tready);
    table_sb.note_request(action, key, value);
  endtask

  // Stop offering and wait until every predicted result has arrived
  task drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (table_sb.pending() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task write_undefined(bit [31:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    table_sb.set_undefined(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task send_random(int ins_pct, int del_pct);
    int        r;
    bit [15:0] key;
    logic [1:0] action;
    r = $urandom_range(99);
    if (r < ins_pct)                action = ACT_INSERT;
    else if (r < ins_pct + del_pct) action = ACT_DELETE;
    else if (r < 96)                action = ACT_LOOKUP;
    else                            action = ACT_RESERVED;  // probe only
    // mostly keys from a small pool so hits and a full table are common
    if ($urandom_range(99) < 85) key = key_pool[$urandom_range(POOL_SIZE - 1)];
    else                         key = 16'($urandom_range(16'hFFFF));
    send_request(action, key, $urandom);
  endtask

  // -------------------------------------------------------------------------
  // Test sequence
  // -------------------------------------------------------------------------
  initial begin
    bit [31:0] cfg_values[8];
    int        mode;

    table_sb = new();
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = 16'($urandom_range(16'hFFFF));
    cfg_values = '{32'h0000_0000, $urandom, 32'hFFFF_FFFF, 32'h8000_0001,
                   $urandom, 32'h0000_0000, 32'h5555_AAAA, $urandom};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_undefined(32'hFFFF_FFFF);

    // Empty table: lookup miss, delete miss, probe miss
    send_request(ACT_LOOKUP, 16'h1234, 32'h1111_1111);
    send_request(ACT_DELETE, 16'h1234, 32'h0);
    send_request(ACT_RESERVED, 16'h1234, 32'h0);
    // Key extremes, duplicate insert keeps the old value
    send_request(ACT_INSERT, 16'h0000, 32'h0000_0000);
    send_request(ACT_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(ACT_INSERT, 16'hFFFF, 32'h1234_5678);
    send_request(ACT_LOOKUP, 16'hFFFF, 32'h0);
    send_request(ACT_LOOKUP, 16'h0000, 32'h0);
    send_request(ACT_RESERVED, 16'hFFFF, 32'h0);
    send_request(ACT_LOOKUP, 16'h5A5A, 32'h0);
    // Fill the table, then overflow it
    for (int i = 0; i < TABLE_DEPTH - 2; i++)
      send_request(ACT_INSERT, 16'(16'h0100 + i), $urandom);
    send_request(ACT_INSERT, 16'hBEEF, 32'hCAFE_0001);
    send_request(ACT_LOOKUP, 16'h010D, 32'h0);
    // Delete in the middle, at the head and at the tail
    send_request(ACT_DELETE, 16'h0105, 32'h0);
    send_request(ACT_LOOKUP, 16'h0106, 32'h0);
    send_request(ACT_DELETE, 16'h0000, 32'h0);
    send_request(ACT_DELETE, 16'h010D, 32'h0);
    send_request(ACT_LOOKUP, 16'hFFFF, 32'h0);
    send_request(ACT_LOOKUP, 16'h0105, 32'h0);
    drain_results();

    // Random phases: idle mode cycles, insert/delete mix alternates
    for (int phase = 0; phase < 8; phase++) begin
      write_undefined(cfg_values[phase]);
      mode = phase % 4;
      sender_idle_pct = (mode == 1) ? 58 : (mode == 3) ? 16 : 0;
      recv_stall_pct  = (mode == 2) ? 58 : (mode == 3) ? 16 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ((phase / 2) % 2 == 0) send_random(55, 20);
        else                      send_random(25, 50);
      end
      drain_results();
    end

    // Back-pressure: hold the result side while requests keep coming
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_req = 1'b1;
    for (int n = 0; n < 40; n++) send_random(40, 30);
    drain_results();

    repeat (4) @(posedge clk);
    if (table_sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
